@@ hw/rtl/hsvrgb_pkg.sv @@
// Shared types, constants and arithmetic helpers for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsvrgb_pkg;

    // Fixed-point format: channels use 2^FRAC_BITS as 1.0.
    localparam int FRAC_BITS        = 12;
    localparam int HUE_W            = 15;
    localparam int CHAN_W           = 13;
    localparam int PROD_W           = 2 * CHAN_W;
    localparam int SECTOR_W         = 4;
    localparam int REM_W            = 12;

    // One 60-degree sector spans 3840 hue steps; a 15-bit hue reaches sector 8.
    localparam int SECTOR_STEPS     = 3840;
    localparam int NUM_SECTORS_MAX  = 8;

    // The fraction rem * 4096 / 3840 equals rem + rem / 15. The quotient by 15
    // is taken as (rem * 4370) >> 16, which is exact for every rem below 3840.
    localparam int FRAC_RECIP       = 4370;
    localparam int FRAC_RECIP_W     = 13;
    localparam int FRAC_RECIP_SHIFT = 16;
    localparam int RECIP_PROD_W     = REM_W + FRAC_RECIP_W;

    // Number of register stages from input to output.
    localparam int NUM_STAGES       = 5;

    localparam logic [CHAN_W-1:0] ONE = CHAN_W'(1 << FRAC_BITS);

    // Sector codes; every code above the magenta-to-red sector behaves like it.
    localparam logic [SECTOR_W-1:0] SECTOR_RED_YEL = SECTOR_W'(0);
    localparam logic [SECTOR_W-1:0] SECTOR_YEL_GRN = SECTOR_W'(1);
    localparam logic [SECTOR_W-1:0] SECTOR_GRN_CYN = SECTOR_W'(2);
    localparam logic [SECTOR_W-1:0] SECTOR_CYN_BLU = SECTOR_W'(3);
    localparam logic [SECTOR_W-1:0] SECTOR_BLU_MAG = SECTOR_W'(4);

    // Input and output words.
    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
    } t_hsv_word;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb_word;

    // Stage payloads.
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [REM_W-1:0]    rem;
        logic [CHAN_W-1:0]   sat;
        logic [CHAN_W-1:0]   val;
    } t_s1_word;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [CHAN_W-1:0]   frac;
        logic [CHAN_W-1:0]   sat;
        logic [CHAN_W-1:0]   val;
        logic [CHAN_W-1:0]   p;
    } t_s2_word;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [CHAN_W-1:0]   val;
        logic [CHAN_W-1:0]   p;
        logic [CHAN_W-1:0]   sf;
        logic [CHAN_W-1:0]   sg;
    } t_s3_word;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [CHAN_W-1:0]   val;
        logic [CHAN_W-1:0]   p;
        logic [CHAN_W-1:0]   q;
        logic [CHAN_W-1:0]   t;
    } t_s4_word;

    // Load enables for the datapath stages held outside the top level.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_pipe_ctl;

    // Limit a channel to 1.0.
    function automatic logic [CHAN_W-1:0] clamp_one(input logic [CHAN_W-1:0] x);
        return (x > ONE) ? ONE : x;
    endfunction

    // Fixed-point product, truncated back to the channel format.
    function automatic logic [CHAN_W-1:0] scale(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(a) * PROD_W'(b);
        return prod[FRAC_BITS +: CHAN_W];
    endfunction

endpackage

@@ hw/rtl/hsvrgb_front.sv @@
// Front stages: sector decode and remainder, then fraction and the p term.
`timescale 1ns / 1ps

module hsvrgb_front import hsvrgb_pkg::*; (
    input  logic      i_clk,
    input  t_hsv_word i_hsv,
    input  t_pipe_ctl i_ctl,
    output t_s2_word  o_s2
);

    t_s1_word                r_s1;
    t_s1_word                n_s1;
    t_s2_word                r_s2;
    t_s2_word                n_s2;
    logic [SECTOR_W-1:0]     sector;
    logic [HUE_W-1:0]        sector_base;
    logic [RECIP_PROD_W-1:0] recip_prod;

    // Stage 1: count the sector boundaries below the hue and clamp the inputs.
    always_comb begin
        sector = '0;
        for (int k = 1; k <= NUM_SECTORS_MAX; k++) begin
            if (i_hsv.hue >= HUE_W'(k * SECTOR_STEPS)) begin
                sector = sector + SECTOR_W'(1);
            end
        end
        sector_base   = HUE_W'(sector) * HUE_W'(SECTOR_STEPS);
        n_s1.sector   = sector;
        n_s1.rem      = REM_W'(i_hsv.hue - sector_base);
        n_s1.sat      = clamp_one(i_hsv.sat);
        n_s1.val      = clamp_one(i_hsv.val);
    end

    // Stage 2: fraction within the sector and p = v(1 - s).
    always_comb begin
        recip_prod  = RECIP_PROD_W'(r_s1.rem) * RECIP_PROD_W'(FRAC_RECIP);
        n_s2.sector = r_s1.sector;
        n_s2.frac   = CHAN_W'(r_s1.rem) + CHAN_W'(recip_prod >> FRAC_RECIP_SHIFT);
        n_s2.sat    = r_s1.sat;
        n_s2.val    = r_s1.val;
        n_s2.p      = scale(r_s1.val, ONE - r_s1.sat);
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_s1 <= n_s1;
        end
        if (i_ctl.ld2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

@@ hw/rtl/hsvrgb_mult.sv @@
// Product stages: saturation times fraction, then the q and t terms.
`timescale 1ns / 1ps

module hsvrgb_mult import hsvrgb_pkg::*; (
    input  logic      i_clk,
    input  t_s2_word  i_s2,
    input  t_pipe_ctl i_ctl,
    output t_s4_word  o_s4
);

    t_s3_word r_s3;
    t_s3_word n_s3;
    t_s4_word r_s4;
    t_s4_word n_s4;

    // Stage 3: s*f and s*(1 - f).
    always_comb begin
        n_s3.sector = i_s2.sector;
        n_s3.val    = i_s2.val;
        n_s3.p      = i_s2.p;
        n_s3.sf     = scale(i_s2.sat, i_s2.frac);
        n_s3.sg     = scale(i_s2.sat, ONE - i_s2.frac);
    end

    // Stage 4: q = v(1 - s*f) and t = v(1 - s(1 - f)).
    always_comb begin
        n_s4.sector = r_s3.sector;
        n_s4.val    = r_s3.val;
        n_s4.p      = r_s3.p;
        n_s4.q      = scale(r_s3.val, ONE - r_s3.sf);
        n_s4.t      = scale(r_s3.val, ONE - r_s3.sg);
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_s3 <= n_s3;
        end
        if (i_ctl.ld4) begin
            r_s4 <= n_s4;
        end
    end

    assign o_s4 = r_s4;

endmodule

@@ hw/rtl/hsv_to_rgb_converter_core.sv @@
// Top level of the HSV to RGB converter: stage control, channel select, output word.
`timescale 1ns / 1ps

// Converts one HSV pixel per clock into RGB while the output is not stalled,
// all channels in fixed point with 4096 as 1.0 and hue in 1/64-degree steps.
// The datapath is five register stages (sector decode, fraction and p, the two
// saturation products, q and t, channel select), and a new word can be taken
// in every cycle unless the output stalls. Each stage holds its word while the
// next one cannot take it; bubbles close up, so the input stays ready until
// all five stages hold words and the output is stalled. Zero saturation needs
// no special path: p, q and t all equal value then.
module hsv_to_rgb_converter_core import hsvrgb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_hsv_word i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_rgb_word o_out_data
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] stage_en;
    logic [NUM_STAGES-1:0] stage_in_vld;
    t_pipe_ctl             pipe_ctl;
    t_s2_word              s2_word;
    t_s4_word              s4_word;
    t_rgb_word             r_out;
    t_rgb_word             n_out;

    // A stage loads when it is empty or its word moves on in the same cycle.
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
        stage_in_vld[0] = i_in_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            stage_in_vld[k] = r_vld[k-1];
        end
        for (int k = 0; k < NUM_STAGES; k++) begin
            n_vld[k] = stage_en[k] ? stage_in_vld[k] : r_vld[k];
        end
    end

    assign pipe_ctl.ld1 = stage_en[0];
    assign pipe_ctl.ld2 = stage_en[1];
    assign pipe_ctl.ld3 = stage_en[2];
    assign pipe_ctl.ld4 = stage_en[3];

    hsvrgb_front u_front (
        .i_clk (i_clk),
        .i_hsv (i_in_data),
        .i_ctl (pipe_ctl),
        .o_s2  (s2_word)
    );

    hsvrgb_mult u_mult (
        .i_clk (i_clk),
        .i_s2  (s2_word),
        .i_ctl (pipe_ctl),
        .o_s4  (s4_word)
    );

    // Stage 5: assign v, p, q and t to the channels by sector.
    always_comb begin
        case (s4_word.sector)
            SECTOR_RED_YEL: begin
                n_out.red   = s4_word.val;
                n_out.green = s4_word.t;
                n_out.blue  = s4_word.p;
            end
            SECTOR_YEL_GRN: begin
                n_out.red   = s4_word.q;
                n_out.green = s4_word.val;
                n_out.blue  = s4_word.p;
            end
            SECTOR_GRN_CYN: begin
                n_out.red   = s4_word.p;
                n_out.green = s4_word.val;
                n_out.blue  = s4_word.t;
            end
            SECTOR_CYN_BLU: begin
                n_out.red   = s4_word.p;
                n_out.green = s4_word.q;
                n_out.blue  = s4_word.val;
            end
            SECTOR_BLU_MAG: begin
                n_out.red   = s4_word.t;
                n_out.green = s4_word.p;
                n_out.blue  = s4_word.val;
            end
            default: begin
                // Last sector, and the full circle and beyond.
                n_out.red   = s4_word.val;
                n_out.green = s4_word.p;
                n_out.blue  = s4_word.q;
            end
        endcase
    end

    // Valid bits and the output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
        if (stage_en[NUM_STAGES-1]) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = stage_en[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // An accepted word lands in the first stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    // A stalled output word is not dropped.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NUM_STAGES-1] && !i_out_ready) |=> r_vld[NUM_STAGES-1])
        else $error("stalled output word was lost");

    // The input is held off only when every stage holds a word.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_vld == {NUM_STAGES{1'b1}}))
        else $error("input held off with an empty stage");

    // p, q and t never exceed value.
    a_terms_le_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_STAGES-2] |-> (s4_word.p <= s4_word.val && s4_word.q <= s4_word.val
                                 && s4_word.t <= s4_word.val))
        else $error("derived term above value");

    // Every output channel stays within 0 to 1.0.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.red <= ONE && o_out_data.green <= ONE
                         && o_out_data.blue <= ONE))
        else $error("output channel above 1.0");
`endif

endmodule

@@ bench/tb_hsv_to_rgb_converter_core.sv @@
// Self-checking testbench for the HSV to RGB converter core.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter_core;
    import hsvrgb_pkg::*;

    localparam int          HALF_PERIOD  = 6;
    localparam int          RESET_CYCLES = 9;
    localparam int          RANDOM_PIXELS = 650;
    localparam int unsigned UNITY        = 1 << FRAC_BITS;
    localparam int unsigned HUE_CIRCLE   = 6 * SECTOR_STEPS;
    localparam int unsigned HUE_TOP      = (1 << HUE_W) - 1;
    localparam int unsigned CHAN_TOP     = (1 << CHAN_W) - 1;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_hsv_word i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_rgb_word o_out_data;

    t_hsv_word pixels_to_send[$];
    t_rgb_word rgb_awaited[$];
    int        error_count = 0;
    bit        done_sending = 1'b0;

    // Idle control for each side: calm stretches have no gaps at all.
    int send_gap       = 0;
    int send_calm_left = 0;
    bit send_calm      = 1'b0;
    int recv_gap       = 0;
    int recv_calm_left = 0;
    bit recv_calm      = 1'b0;

    hsv_to_rgb_converter_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock generation.
    always #HALF_PERIOD i_clk = ~i_clk;

    // Expected RGB for one pixel: clamp, split the hue, form p, q, t, then route.
    function automatic t_rgb_word predict_rgb(input t_hsv_word px);
        int unsigned          hue, s, v, f, p, q, t, r, g, b;
        logic [SECTOR_W-1:0]  sector;
        t_rgb_word            rgb;
        hue = px.hue;
        s = (px.sat > UNITY) ? UNITY : px.sat;
        v = (px.val > UNITY) ? UNITY : px.val;
        sector = SECTOR_W'(hue / SECTOR_STEPS);
        f = ((hue % SECTOR_STEPS) * UNITY) / SECTOR_STEPS;
        p = (v * (UNITY - s)) >> FRAC_BITS;
        q = (v * (UNITY - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
        t = (v * (UNITY - ((s * (UNITY - f)) >> FRAC_BITS))) >> FRAC_BITS;
        if (s == 0) begin
            r = v;
            g = v;
            b = v;
        end else begin
            case (sector)
                SECTOR_RED_YEL: begin r = v; g = t; b = p; end
                SECTOR_YEL_GRN: begin r = q; g = v; b = p; end
                SECTOR_GRN_CYN: begin r = p; g = v; b = t; end
                SECTOR_CYN_BLU: begin r = p; g = q; b = v; end
                SECTOR_BLU_MAG: begin r = t; g = p; b = v; end
                // The full circle and every hue past it keep the last order.
                default:        begin r = v; g = p; b = q; end
            endcase
        end
        rgb.red   = CHAN_W'(r);
        rgb.green = CHAN_W'(g);
        rgb.blue  = CHAN_W'(b);
        return rgb;
    endfunction

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) begin
            return 0;
        end else if (roll < 94) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    task automatic queue_pixel(input int unsigned hue, input int unsigned sat,
                               input int unsigned val);
        t_hsv_word px;
        px.hue = HUE_W'(hue);
        px.sat = CHAN_W'(sat);
        px.val = CHAN_W'(val);
        pixels_to_send.push_back(px);
    endtask

    // Driver: presents queued pixels and records the expected RGB on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                rgb_awaited.push_back(predict_rgb(i_in_data));
            end
            if (send_calm_left == 0) begin
                send_calm      = ($urandom_range(0, 9) < 3);
                send_calm_left = $urandom_range(20, 80);
            end else begin
                send_calm_left = send_calm_left - 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pixels_to_send.size() > 0) begin
                    i_in_data  <= pixels_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and a field-by-field check of every output word.
    always @(posedge i_clk) begin
        t_rgb_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (rgb_awaited.size() == 0) begin
                    $error("unexpected output word: red %0d green %0d blue %0d",
                           o_out_data.red, o_out_data.green, o_out_data.blue);
                    error_count = error_count + 1;
                end else begin
                    want = rgb_awaited.pop_front();
                    if (o_out_data.red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, o_out_data.red);
                        error_count = error_count + 1;
                    end
                    if (o_out_data.green !== want.green) begin
                        $error("green: expected %0d, actual %0d",
                               want.green, o_out_data.green);
                        error_count = error_count + 1;
                    end
                    if (o_out_data.blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, o_out_data.blue);
                        error_count = error_count + 1;
                    end
                end
            end
            if (recv_calm_left == 0) begin
                recv_calm      = ($urandom_range(0, 9) < 3);
                recv_calm_left = $urandom_range(20, 80);
            end else begin
                recv_calm_left = recv_calm_left - 1;
            end
            if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                recv_gap = pick_gap(recv_calm);
                i_out_ready <= (recv_gap == 0);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int mode;
        // Zero saturation: every channel follows value.
        queue_pixel(0, 0, 0);
        queue_pixel(0, 0, UNITY);
        queue_pixel(12345, 0, 2000);
        // Middle of each sector at full saturation and value.
        for (int k = 0; k < 6; k++) begin
            queue_pixel(k * SECTOR_STEPS + SECTOR_STEPS / 2, UNITY, UNITY);
        end
        // Sector boundaries, the last step before the full circle and the full circle.
        queue_pixel(SECTOR_STEPS - 1, 3000, 4000);
        queue_pixel(SECTOR_STEPS, 3000, 4000);
        queue_pixel(HUE_CIRCLE - 1, UNITY, UNITY);
        queue_pixel(HUE_CIRCLE, UNITY, UNITY);
        // Hue past the full circle, up to the largest code.
        queue_pixel(25000, 2500, 3500);
        queue_pixel(30000, 2500, 3500);
        queue_pixel(HUE_TOP, 2500, 3500);
        // Saturation or value above one are clamped.
        queue_pixel(7000, CHAN_TOP, 3000);
        queue_pixel(15000, 2000, CHAN_TOP);
        queue_pixel(20000, 5000, 6000);
        // Smallest nonzero and just below one.
        queue_pixel(100, 1, 1);
        queue_pixel(11000, UNITY - 1, UNITY - 1);

        // Random pixels: mostly in range, some with zero saturation, some raw codes.
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                queue_pixel($urandom_range(0, HUE_TOP), $urandom_range(0, CHAN_TOP),
                            $urandom_range(0, CHAN_TOP));
            end else if (mode == 1) begin
                queue_pixel($urandom_range(0, HUE_CIRCLE), 0, $urandom_range(0, UNITY));
            end else begin
                queue_pixel($urandom_range(0, HUE_CIRCLE), $urandom_range(0, UNITY),
                            $urandom_range(0, UNITY));
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every pixel to be taken and every result to come back.
        while (pixels_to_send.size() > 0 || i_in_valid || rgb_awaited.size() > 0) begin
            @(posedge i_clk);
        end
        // Keep the clock running to catch any stray output word.
        repeat (NUM_STAGES * 4) @(posedge i_clk);
        done_sending = 1'b1;
        if (error_count == 0) begin
            $display("tb_hsv_to_rgb_converter_core: PASS");
        end else begin
            $display("tb_hsv_to_rgb_converter_core: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        if (!done_sending) begin
            $display("tb_hsv_to_rgb_converter_core: FAIL");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_front.sv
hw/rtl/hsvrgb_mult.sv
hw/rtl/hsv_to_rgb_converter_core.sv
bench/tb_hsv_to_rgb_converter_core.sv
